// ===== src/pwl_pkg.sv =====
// ----------------------------------------------------------------------------
// pwl_pkg
// Shared widths, step counts and breakpoint reset values for the
// piecewise linear temperature scaler.
// ----------------------------------------------------------------------------
`default_nettype none

package pwl_pkg;

  localparam int TABLE_POINTS_DEF = 9;
  localparam int RESET_POINTS     = 9;

  localparam int CODE_W  = 16;
  localparam int TEMP_W  = 19;
  localparam int IDX_IN_W = 4;

  // |y2 - y1| fits 19 bits, (x - x1) and (x2 - x1) fit 16 bits unsigned
  localparam int MAG_W   = 19;
  localparam int DX_W    = 16;
  localparam int PROD_W  = MAG_W + DX_W;
  localparam int MUL_STEPS = DX_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W  = $clog2(DIV_STEPS + 1);

  localparam logic MODE_CONVERT = 1'b0;
  localparam logic MODE_WRITE   = 1'b1;

  localparam logic signed [CODE_W-1:0] RST_CODE [RESET_POINTS] = '{
    16'sd32000, 16'sd6416, 16'sd2592, 16'sd128, 16'sd0,
    -16'sd128, -16'sd2592, -16'sd6416, -16'sd14080
  };

  localparam logic signed [TEMP_W-1:0] RST_TEMP [RESET_POINTS] = '{
    19'sd125000, 19'sd25063, 19'sd10125, 19'sd500, 19'sd0,
    -19'sd500, -19'sd10125, -19'sd25063, -19'sd55000
  };

  // entries past the reset list repeat the last pair
  function automatic logic signed [CODE_W-1:0] reset_code(input int k);
    int idx;
    idx = (k < RESET_POINTS) ? k : RESET_POINTS - 1;
    return RST_CODE[idx];
  endfunction

  function automatic logic signed [TEMP_W-1:0] reset_temp(input int k);
    int idx;
    idx = (k < RESET_POINTS) ? k : RESET_POINTS - 1;
    return RST_TEMP[idx];
  endfunction

endpackage

`default_nettype wire

// ===== src/piecewise_linear_temp_scaler_core.sv =====
// Timing: a mode-1 beat passes from acceptance through the finish state to the output
// register; an interpolating conversion walks the table (k leading entries at or above
// the code, k below TABLE_POINTS), then runs the bit-serial multiply, the restoring
// divide and the finish state. Saturated codes skip both.
// One item at a time: stall_o holds off the next beat until the current one leaves the
// finish state. Reset loads the nine breakpoints and empties the pipe.
// ----------------------------------------------------------------------------
// piecewise_linear_temp_scaler_core
// Raw sensor code to milli-degrees C by interpolation over a breakpoint
// table, with a serial table walk, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_temp_scaler_core #(
  parameter int TABLE_POINTS = pwl_pkg::TABLE_POINTS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output      logic                                stall_o,
  input  wire logic                                mode_i,
  input  wire logic signed [pwl_pkg::CODE_W-1:0]   raw_code_i,
  input  wire logic        [pwl_pkg::IDX_IN_W-1:0] entry_index_i,
  input  wire logic signed [pwl_pkg::CODE_W-1:0]   entry_code_i,
  input  wire logic signed [pwl_pkg::TEMP_W-1:0]   entry_temp_i,
  output      logic                                valid_o,
  input  wire logic                                stall_i,
  output      logic signed [pwl_pkg::TEMP_W-1:0]   temp_milli_o,
  output      logic                                clamped_o
);

  localparam int IDX_W = (TABLE_POINTS > 1) ? $clog2(TABLE_POINTS) : 1;
  localparam int CNT_W = $clog2(TABLE_POINTS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q;

  logic signed [pwl_pkg::CODE_W-1:0] tbl_code_q [TABLE_POINTS];
  logic signed [pwl_pkg::TEMP_W-1:0] tbl_temp_q [TABLE_POINTS];

  logic [CNT_W-1:0]                  cnt_q;
  logic signed [pwl_pkg::CODE_W-1:0] x_q;
  logic signed [pwl_pkg::CODE_W-1:0] prev_code_q;
  logic signed [pwl_pkg::TEMP_W-1:0] prev_temp_q;
  logic signed [pwl_pkg::TEMP_W-1:0] base_q;
  logic                              neg_q;
  logic [pwl_pkg::MAG_W-1:0]         mcand_q;
  logic [pwl_pkg::DX_W-1:0]          mplier_q;
  logic [pwl_pkg::DX_W-1:0]          div_q;
  logic [pwl_pkg::PROD_W-1:0]        acc_q;
  logic [pwl_pkg::DX_W-1:0]          rem_q;
  logic [pwl_pkg::STEP_W-1:0]        step_q;
  logic signed [pwl_pkg::TEMP_W-1:0] res_q;
  logic                              clamp_q;

  logic                              out_vld_q;
  logic signed [pwl_pkg::TEMP_W-1:0] out_temp_q;
  logic                              out_clamp_q;

  logic                              in_acc;
  logic                              walk_end;
  logic [IDX_W-1:0]                  rd_idx;
  logic signed [pwl_pkg::CODE_W-1:0] rd_code;
  logic signed [pwl_pkg::TEMP_W-1:0] rd_temp;
  logic signed [pwl_pkg::TEMP_W:0]   dy;
  logic [pwl_pkg::TEMP_W:0]          dy_abs;
  logic signed [pwl_pkg::CODE_W:0]   dx;
  logic signed [pwl_pkg::CODE_W:0]   dspan;
  logic [pwl_pkg::PROD_W-1:0]        acc_add;
  logic [pwl_pkg::DX_W:0]            trial;
  logic                              qbit;
  logic [pwl_pkg::PROD_W-1:0]        quo_nxt;
  logic signed [pwl_pkg::TEMP_W:0]   quo_s;
  logic signed [pwl_pkg::TEMP_W:0]   res_sum;
  logic                              out_free;

  assign in_acc   = valid_i && !stall_o;
  assign stall_o  = (state_q != ST_IDLE);
  assign out_free = !out_vld_q || !stall_i;
  assign walk_end = (cnt_q == CNT_W'(TABLE_POINTS));
  assign rd_idx   = cnt_q[IDX_W-1:0];
  assign rd_code  = tbl_code_q[rd_idx];
  assign rd_temp  = tbl_temp_q[rd_idx];

  // segment between the current entry (x1, y1) and the previous one (x2, y2)
  assign dy     = {prev_temp_q[pwl_pkg::TEMP_W-1], prev_temp_q}
                - {rd_temp[pwl_pkg::TEMP_W-1], rd_temp};
  assign dy_abs = dy[pwl_pkg::TEMP_W] ? (pwl_pkg::TEMP_W+1)'(-dy) : dy;
  assign dx     = {x_q[pwl_pkg::CODE_W-1], x_q} - {rd_code[pwl_pkg::CODE_W-1], rd_code};
  assign dspan  = {prev_code_q[pwl_pkg::CODE_W-1], prev_code_q}
                - {rd_code[pwl_pkg::CODE_W-1], rd_code};

  // MSB-first shift-add, one multiplier bit per cycle
  assign acc_add = {acc_q[pwl_pkg::PROD_W-2:0], 1'b0}
                 + (mplier_q[pwl_pkg::DX_W-1] ? pwl_pkg::PROD_W'(mcand_q) : '0);

  // restoring divide, one quotient bit per cycle, quotient shifts into acc
  assign trial   = {rem_q, acc_q[pwl_pkg::PROD_W-1]};
  assign qbit    = (trial >= {1'b0, div_q});
  assign quo_nxt = {acc_q[pwl_pkg::PROD_W-2:0], qbit};
  assign quo_s   = neg_q ? -$signed({1'b0, quo_nxt[pwl_pkg::MAG_W-1:0]})
                         :  $signed({1'b0, quo_nxt[pwl_pkg::MAG_W-1:0]});
  assign res_sum = quo_s + {base_q[pwl_pkg::TEMP_W-1], base_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TABLE_POINTS; k++) begin
        tbl_code_q[k] <= pwl_pkg::reset_code(k);
        tbl_temp_q[k] <= pwl_pkg::reset_temp(k);
      end
    end else if (in_acc && mode_i == pwl_pkg::MODE_WRITE) begin
      for (int k = 0; k < TABLE_POINTS; k++) begin
        if (32'(entry_index_i) == k) begin
          tbl_code_q[k] <= entry_code_i;
          tbl_temp_q[k] <= entry_temp_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= (mode_i == pwl_pkg::MODE_WRITE) ? ST_FIN : ST_WALK;
            cnt_q   <= '0;
          end
        end
        ST_WALK: begin
          if (walk_end) begin
            state_q <= ST_FIN;
          end else if (rd_code >= x_q) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end else if (cnt_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_MUL;
            step_q  <= '0;
          end
        end
        ST_MUL: begin
          if (step_q == pwl_pkg::STEP_W'(pwl_pkg::MUL_STEPS - 1)) begin
            state_q <= ST_DIV;
            step_q  <= '0;
          end else begin
            step_q <= step_q + pwl_pkg::STEP_W'(1);
          end
        end
        ST_DIV: begin
          if (step_q == pwl_pkg::STEP_W'(pwl_pkg::DIV_STEPS - 1)) begin
            state_q <= ST_FIN;
          end else begin
            step_q <= step_q + pwl_pkg::STEP_W'(1);
          end
        end
        ST_FIN: begin
          if (out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        x_q     <= raw_code_i;
        res_q   <= '0;
        clamp_q <= 1'b0;
      end
      ST_WALK: begin
        if (walk_end) begin
          res_q   <= prev_temp_q;
          clamp_q <= 1'b1;
        end else if (rd_code >= x_q) begin
          prev_code_q <= rd_code;
          prev_temp_q <= rd_temp;
        end else if (cnt_q == '0) begin
          res_q   <= rd_temp;
          clamp_q <= 1'b1;
        end else begin
          base_q   <= rd_temp;
          neg_q    <= dy[pwl_pkg::TEMP_W];
          mcand_q  <= dy_abs[pwl_pkg::MAG_W-1:0];
          mplier_q <= dx[pwl_pkg::DX_W-1:0];
          div_q    <= dspan[pwl_pkg::DX_W-1:0];
          acc_q    <= '0;
        end
      end
      ST_MUL: begin
        acc_q    <= acc_add;
        mplier_q <= {mplier_q[pwl_pkg::DX_W-2:0], 1'b0};
        rem_q    <= '0;
      end
      ST_DIV: begin
        acc_q <= quo_nxt;
        rem_q <= qbit ? pwl_pkg::DX_W'(trial - {1'b0, div_q}) : trial[pwl_pkg::DX_W-1:0];
        if (step_q == pwl_pkg::STEP_W'(pwl_pkg::DIV_STEPS - 1)) begin
          res_q   <= res_sum[pwl_pkg::TEMP_W-1:0];
          clamp_q <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_FIN && out_free) begin
      out_vld_q <= 1'b1;
    end else if (!stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && out_free) begin
      out_temp_q  <= res_q;
      out_clamp_q <= clamp_q;
    end
  end

  assign valid_o      = out_vld_q;
  assign temp_milli_o = out_temp_q;
  assign clamped_o    = out_clamp_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_q != '0))
    else $error("divisor is zero during divide");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q <= CNT_W'(TABLE_POINTS)))
    else $error("table walk ran past the last entry");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_o) |-> ($past(state_q) == ST_FIN))
    else $error("result beat raised outside finish state");

endmodule

`default_nettype wire

// ===== dv/piecewise_linear_temp_scaler_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_temp_scaler_core_tb
// Drives conversions and breakpoint writes through the valid/stall input
// channel, predicts each reading from a private copy of the breakpoint table
// and checks every output beat in order, under random bursts and stalls.
// ----------------------------------------------------------------------------

module piecewise_linear_temp_scaler_core_tb;

  localparam int NPTS       = pwl_pkg::TABLE_POINTS_DEF;
  localparam int RAND_ITEMS = 1625;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYC  = 80;

  typedef struct packed {
    logic signed [pwl_pkg::TEMP_W-1:0] temp;
    logic                              clamped;
  } reading_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow breakpoint table plus queue of predicted readings
  // --------------------------------------------------------------------------
  class temp_scoreboard;
    logic signed [pwl_pkg::CODE_W-1:0] code_tab [NPTS];
    logic signed [pwl_pkg::TEMP_W-1:0] temp_tab [NPTS];
    reading_t                          pending_readings [$];
    int errors;
    int n_convert, n_interp, n_saturated, n_write, n_write_skip, n_checked;

    function new();
      int rc [9];
      int rt [9];
      rc = '{32000, 6416, 2592, 128, 0, -128, -2592, -6416, -14080};
      rt = '{125000, 25063, 10125, 500, 0, -500, -10125, -25063, -55000};
      for (int k = 0; k < NPTS; k++) begin
        code_tab[k] = pwl_pkg::CODE_W'(rc[(k < 9) ? k : 8]);
        temp_tab[k] = pwl_pkg::TEMP_W'(rt[(k < 9) ? k : 8]);
      end
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // predicted reading for one accepted input beat
    function void note_beat(input logic mode,
                            input logic signed [pwl_pkg::CODE_W-1:0] raw,
                            input logic [pwl_pkg::IDX_IN_W-1:0] idx,
                            input logic signed [pwl_pkg::CODE_W-1:0] code,
                            input logic signed [pwl_pkg::TEMP_W-1:0] temp);
      longint   x, x1, y1, x2, y2, val;
      int       i;
      reading_t r;
      r = '0;
      if (mode == pwl_pkg::MODE_WRITE) begin
        n_write++;
        if (idx < NPTS) begin
          code_tab[idx] = code;
          temp_tab[idx] = temp;
        end else begin
          n_write_skip++;
        end
      end else begin
        n_convert++;
        x = raw;
        i = 0;
        while (i < NPTS && code_tab[i] >= x) i++;
        if (i == 0) begin
          r.temp = temp_tab[0];
          r.clamped = 1'b1;
          n_saturated++;
        end else if (i >= NPTS) begin
          r.temp = temp_tab[NPTS-1];
          r.clamped = 1'b1;
          n_saturated++;
        end else begin
          x1 = code_tab[i];
          y1 = temp_tab[i];
          x2 = code_tab[i-1];
          y2 = temp_tab[i-1];
          // longint division truncates toward zero
          val = ((y2 - y1) * (x - x1)) / (x2 - x1) + y1;
          r.temp = val[pwl_pkg::TEMP_W-1:0];
          n_interp++;
        end
      end
      pending_readings.push_back(r);
    endfunction

    task check_result(input logic signed [pwl_pkg::TEMP_W-1:0] temp, input logic clamped);
      reading_t r;
      if (pending_readings.size() == 0) begin
        report($sformatf("unexpected reading temp=%0d clamped=%0b", temp, clamped));
      end else begin
        r = pending_readings.pop_front();
        n_checked++;
        if (temp !== r.temp)
          report($sformatf("temp_milli got %0d, want %0d", temp, r.temp));
        if (clamped !== r.clamped)
          report($sformatf("clamped got %0b, want %0b", clamped, r.clamped));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic                                clk_i         = 1'b0;
  logic                                rst_ni        = 1'b0;
  logic                                valid_i       = 1'b0;
  logic                                stall_o;
  logic                                mode_i        = pwl_pkg::MODE_CONVERT;
  logic signed [pwl_pkg::CODE_W-1:0]   raw_code_i    = '0;
  logic        [pwl_pkg::IDX_IN_W-1:0] entry_index_i = '0;
  logic signed [pwl_pkg::CODE_W-1:0]   entry_code_i  = '0;
  logic signed [pwl_pkg::TEMP_W-1:0]   entry_temp_i  = '0;
  logic                                valid_o;
  logic                                stall_i       = 1'b0;
  logic signed [pwl_pkg::TEMP_W-1:0]   temp_milli_o;
  logic                                clamped_o;

  piecewise_linear_temp_scaler_core #(
    .TABLE_POINTS (NPTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_i),
    .stall_o       (stall_o),
    .mode_i        (mode_i),
    .raw_code_i    (raw_code_i),
    .entry_index_i (entry_index_i),
    .entry_code_i  (entry_code_i),
    .entry_temp_i  (entry_temp_i),
    .valid_o       (valid_o),
    .stall_i       (stall_i),
    .temp_milli_o  (temp_milli_o),
    .clamped_o     (clamped_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  temp_scoreboard sb;
  int items_sent;
  int burst_left;
  int idle_cycles;

  // --------------------------------------------------------------------------
  // Output side: stall pattern and result checking
  // --------------------------------------------------------------------------
  int stall_phase;
  int stall_left;
  int stall_tick;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_phase = $urandom_range(0, 3);
      stall_left  = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_phase)
      0: stall_i <= 1'b0;
      1: stall_i <= ($urandom_range(0, 9) < 3);
      2: stall_i <= ($urandom_range(0, 9) < 8);
      default: stall_i <= ((stall_tick % 8) < 5);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) sb.check_result(temp_milli_o, clamped_o);
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("Watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic send(input logic mode, input logic signed [pwl_pkg::CODE_W-1:0] raw,
                      input logic [pwl_pkg::IDX_IN_W-1:0] idx,
                      input logic signed [pwl_pkg::CODE_W-1:0] code,
                      input logic signed [pwl_pkg::TEMP_W-1:0] temp);
    int gap;
    valid_i       <= 1'b1;
    mode_i        <= mode;
    raw_code_i    <= raw;
    entry_index_i <= idx;
    entry_code_i  <= code;
    entry_temp_i  <= temp;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    sb.note_beat(mode, raw, idx, code, temp);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) == 0) gap = 0;
      else if ($urandom_range(0, 7) == 0) gap = $urandom_range(13, 80);
      else gap = $urandom_range(1, 12);
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic signed [pwl_pkg::CODE_W-1:0] rand_code();
    logic [pwl_pkg::CODE_W-1:0] v;
    v = pwl_pkg::CODE_W'($urandom);
    return v;
  endfunction

  function automatic logic signed [pwl_pkg::TEMP_W-1:0] rand_temp();
    logic [pwl_pkg::TEMP_W-1:0] v;
    v = pwl_pkg::TEMP_W'($urandom);
    return v;
  endfunction

  function automatic logic signed [pwl_pkg::CODE_W-1:0] clip_code(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return pwl_pkg::CODE_W'(v);
  endfunction

  task automatic convert(input logic signed [pwl_pkg::CODE_W-1:0] raw);
    send(pwl_pkg::MODE_CONVERT, raw, 4'($urandom), rand_code(), rand_temp());
  endtask

  task automatic write_entry(input logic [pwl_pkg::IDX_IN_W-1:0] idx,
                             input logic signed [pwl_pkg::CODE_W-1:0] code,
                             input logic signed [pwl_pkg::TEMP_W-1:0] temp);
    send(pwl_pkg::MODE_WRITE, rand_code(), idx, code, temp);
  endtask

  // raw codes biased toward the table span and its breakpoints
  function automatic logic signed [pwl_pkg::CODE_W-1:0] pick_raw();
    int r, k, lo, hi;
    r = $urandom_range(0, 9);
    if (r < 3) return rand_code();
    if (r < 6) begin
      k = $urandom_range(0, NPTS - 1);
      return clip_code(int'(sb.code_tab[k]) + $urandom_range(0, 6) - 3);
    end
    lo = int'(sb.code_tab[NPTS-1]) - 4;
    hi = int'(sb.code_tab[0]) + 4;
    if (hi <= lo) return rand_code();
    return clip_code(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // rewrite the whole table with a falling code sequence
  task automatic load_falling_table();
    int codes [$];
    int span, base;
    span = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(16, 4000);
    base = $urandom_range(0, 65535 - span) - 32768;
    for (int k = 0; k < NPTS; k++) codes.push_back(base + int'($urandom_range(0, span)));
    codes.rsort();
    for (int k = 0; k < NPTS; k++)
      write_entry(pwl_pkg::IDX_IN_W'(k), pwl_pkg::CODE_W'(codes[k]), rand_temp());
  endtask

  // keeps order: code lands between its neighbors
  task automatic write_in_order();
    int k, lo, hi;
    k  = $urandom_range(0, NPTS - 1);
    lo = (k == NPTS - 1) ? -32768 : int'(sb.code_tab[k+1]);
    hi = (k == 0) ? 32767 : int'(sb.code_tab[k-1]);
    if (lo > hi) write_entry(pwl_pkg::IDX_IN_W'(k), rand_code(), rand_temp());
    else write_entry(pwl_pkg::IDX_IN_W'(k),
                     pwl_pkg::CODE_W'(lo + int'($urandom_range(0, hi - lo))), rand_temp());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int r;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset table: saturation at both ends, breakpoints and their neighbors
    convert(16'sd32767);
    convert(16'sd32001);
    convert(16'sd32000);
    convert(16'sd31999);
    convert(16'sd6416);
    convert(16'sd6417);
    convert(16'sd129);
    convert(16'sd128);
    convert(16'sd1);
    convert(16'sd0);
    convert(-16'sd1);
    convert(-16'sd128);
    convert(-16'sd14079);
    convert(-16'sd14080);
    convert(-16'sh8000);
    // extreme entries, widest span for the divider
    write_entry(4'd0, 16'sh7fff, 19'sh3ffff);
    write_entry(4'd8, 16'sh8000, 19'sh40000);
    convert(16'sh8000);
    convert(16'sh7fff);
    write_entry(4'd1, 16'sh8000, 19'sh40000);
    convert(16'sd0);
    convert(-16'sd32767);
    // writes outside the table are dropped
    write_entry(4'd9, 16'sd5, 19'sd5);
    write_entry(4'd15, 16'sh7fff, 19'sh3ffff);
    // table no longer falling
    write_entry(4'd2, 16'sd20000, 19'sd0);
    convert(16'sd10000);

    load_falling_table();
    while (items_sent < 26 + RAND_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 72) convert(pick_raw());
      else if (r < 79) write_in_order();
      else if (r < 85)
        write_entry(pwl_pkg::IDX_IN_W'($urandom_range(0, NPTS - 1)), rand_code(),
                    rand_temp());
      else if (r < 89)
        write_entry(pwl_pkg::IDX_IN_W'($urandom_range(NPTS, 15)), rand_code(),
                    rand_temp());
      else load_falling_table();
    end
    valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Run covered %0d conversions (%0d interpolated, %0d saturated), %0d writes",
             sb.n_convert, sb.n_interp, sb.n_saturated, sb.n_write);
    $display("  of which %0d fell outside the table; %0d readings compared",
             sb.n_write_skip, sb.n_checked);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== piecewise_linear_temp_scaler_core.f =====
src/pwl_pkg.sv
src/piecewise_linear_temp_scaler_core.sv
dv/piecewise_linear_temp_scaler_core_tb.sv
